[sv/teq_pkg.sv]
package teq_pkg;

  localparam int TIME_W = 32;
  localparam int KEY_W = 64;
  localparam int HID_W = 8;
  localparam int CNT_OUT_W = 6;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_POOL_DEPTH = 32;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] RETRY_RESET = 32'd1;
  localparam logic [TIME_W-1:0] START_RESET = 32'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RETRY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 1'd1;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_COMPLETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DROPPED    = 2'd1,
    ST_NOT_DUE    = 2'd2,
    ST_NO_INFLIGHT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCH,
    S_SCH_EV,
    S_ENQ_RD,
    S_ENQ_EV,
    S_ENQ_INS,
    S_ENQ_FIX,
    S_CAN_RD,
    S_CAN_EV,
    S_CAN_FIX,
    S_DISP,
    S_DISP_EV,
    S_CPL,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t               opcode;
    logic [TIME_W-1:0] event_time;
    logic [KEY_W-1:0]  msg_key;
    logic [HID_W-1:0]  handler_id;
    logic              handled;
  } in_t;

  typedef struct packed {
    logic                 msg_valid;
    logic [TIME_W-1:0]    msg_time;
    logic [KEY_W-1:0]     out_key;
    logic [HID_W-1:0]     out_handler;
    status_t              status;
    logic [CNT_OUT_W-1:0] used_count;
  } out_t;

endpackage

[sv/timed_event_queue.sv]
// Channel  | Direction | Handshake           | Word
// ---------+-----------+---------------------+-------------------------------
// in       | input     | in_valid / in_ready | teq_pkg::in_t (one command)
// out      | output    | out_valid/out_ready | teq_pkg::out_t (one result)
// cfg      | input     | cfg_we              | cfg_index, cfg_data
//
// After reset the link memory is chained by one pass over every entry;
// in_ready stays low during that pass, configuration writes are taken.
// A handled complete, a dropped schedule and a dispatch on an empty queue go
// straight to the result; any other dispatch first reads the head entry.
// Schedule and re-queue walk the linked queue with one memory read per entry
// visited, then link the entry in. Cancel walks the whole queue and unlinks
// every entry with the key, with an extra link write per entry removed behind
// a kept one; the single shared read port serves all of these walks.
// One command is processed at a time. The result register lets a new word
// be accepted while the previous result waits for out_ready.
module timed_event_queue #(
  parameter int POOL_DEPTH = teq_pkg::DEF_POOL_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  teq_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output teq_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [teq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [teq_pkg::CFG_W-1:0]      cfg_data
);
  import teq_pkg::*;

  // Entry indexes carry one extra code, POOL_DEPTH, that means "no entry".
  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IW = $clog2(POOL_DEPTH + 1);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int PAY_W = KEY_W + HID_W;
  localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);

  // Entry storage: due time, key plus handler, and the link word. All three
  // share one read address and return registered data in the cycle after it.
  logic [TIME_W-1:0] time_mem [POOL_DEPTH];
  logic [PAY_W-1:0]  pay_mem  [POOL_DEPTH];
  logic [IW-1:0]     link_mem [POOL_DEPTH];

  logic              t_we, p_we, l_we;
  logic [AW-1:0]     t_wa, l_wa, rd_addr;
  logic [TIME_W-1:0] t_wd, t_rd;
  logic [PAY_W-1:0]  p_wd, p_rd;
  logic [IW-1:0]     l_wd, l_rd;

  always_ff @(posedge clk) begin
    if (t_we) begin
      time_mem[t_wa] <= t_wd;
    end
    if (p_we) begin
      pay_mem[t_wa] <= p_wd;
    end
    if (l_we) begin
      link_mem[l_wa] <= l_wd;
    end
    t_rd <= time_mem[rd_addr];
    p_rd <= pay_mem[rd_addr];
    l_rd <= link_mem[rd_addr];
  end

  // Control and working registers.
  state_t            state, state_next;
  logic [IW-1:0]     idx, idx_next;
  logic [IW-1:0]     head, head_next;
  logic [IW-1:0]     tail, tail_next;
  logic [IW-1:0]     free_head, free_head_next;
  logic [IW-1:0]     inflight, inflight_next;
  logic [CW-1:0]     count, count_next;
  logic [TIME_W-1:0] cur_time, cur_time_next;
  logic [TIME_W-1:0] retry, retry_next;
  logic              out_valid_next;

  // Per-command registers, no reset needed.
  in_t               req, req_next;
  out_t              res, res_next;
  out_t              out_q, out_q_next;
  logic [IW-1:0]     cur, cur_next;
  logic [IW-1:0]     prev, prev_next;
  logic [IW-1:0]     ent, ent_next;
  logic [TIME_W-1:0] ins_time, ins_time_next;

  logic [TIME_W:0]   retry_sum;
  logic [TIME_W-1:0] retry_time;

  // Re-queue time saturates at the top of the tick range.
  assign retry_sum  = {1'b0, cur_time} + {1'b0, retry};
  assign retry_time = retry_sum[TIME_W] ? '1 : retry_sum[TIME_W-1:0];

  assign in_ready = (state == S_IDLE);
  assign out_data = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx       <= '0;
      head      <= NIL;
      tail      <= NIL;
      free_head <= '0;
      inflight  <= NIL;
      count     <= '0;
      cur_time  <= START_RESET;
      retry     <= RETRY_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      inflight  <= inflight_next;
      count     <= count_next;
      cur_time  <= cur_time_next;
      retry     <= retry_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    res      <= res_next;
    out_q    <= out_q_next;
    cur      <= cur_next;
    prev     <= prev_next;
    ent      <= ent_next;
    ins_time <= ins_time_next;
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    head_next      = head;
    tail_next      = tail;
    free_head_next = free_head;
    inflight_next  = inflight;
    count_next     = count;
    cur_time_next  = cur_time;
    retry_next     = retry;
    out_valid_next = out_valid & ~out_ready;
    req_next       = req;
    res_next       = res;
    out_q_next     = out_q;
    cur_next       = cur;
    prev_next      = prev;
    ent_next       = ent;
    ins_time_next  = ins_time;

    t_we    = 1'b0;
    p_we    = 1'b0;
    l_we    = 1'b0;
    t_wa    = ent[AW-1:0];
    t_wd    = req.event_time;
    p_wd    = {req.msg_key, req.handler_id};
    l_wa    = '0;
    l_wd    = NIL;
    rd_addr = cur[AW-1:0];

    unique case (state)
      S_INIT: begin
        // Chain every entry to the next one; the last one points to nothing.
        l_we     = 1'b1;
        l_wa     = idx[AW-1:0];
        l_wd     = idx + IW'(1);
        idx_next = idx + IW'(1);
        if (idx == NIL - IW'(1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_next = in_data;
          res_next = '0;
          unique case (in_data.opcode)
            OP_SCHEDULE: state_next = S_SCH;
            OP_CANCEL: begin
              prev_next  = NIL;
              cur_next   = head;
              state_next = S_CAN_RD;
            end
            OP_DISPATCH: state_next = S_DISP;
            OP_COMPLETE: state_next = S_CPL;
          endcase
        end
      end

      S_SCH: begin
        if (free_head == NIL) begin
          res_next.status = ST_DROPPED;
          state_next      = S_DONE;
        end else begin
          rd_addr       = free_head[AW-1:0];
          ent_next      = free_head;
          ins_time_next = req.event_time;
          state_next    = S_SCH_EV;
        end
      end

      S_SCH_EV: begin
        free_head_next = l_rd;
        t_we           = 1'b1;
        p_we           = 1'b1;
        prev_next      = NIL;
        cur_next       = head;
        state_next     = S_ENQ_RD;
      end

      S_ENQ_RD: begin
        if (cur == NIL) begin
          state_next = S_ENQ_INS;
        end else begin
          state_next = S_ENQ_EV;
        end
      end

      S_ENQ_EV: begin
        // Stop before the first entry that is strictly later, so equal
        // times keep their order.
        if (t_rd > ins_time) begin
          state_next = S_ENQ_INS;
        end else begin
          prev_next  = cur;
          cur_next   = l_rd;
          state_next = S_ENQ_RD;
        end
      end

      S_ENQ_INS: begin
        l_we       = 1'b1;
        l_wa       = ent[AW-1:0];
        l_wd       = cur;
        count_next = count + CW'(1);
        if (cur == NIL) begin
          tail_next = ent;
        end
        if (prev == NIL) begin
          head_next  = ent;
          state_next = S_DONE;
        end else begin
          state_next = S_ENQ_FIX;
        end
      end

      S_ENQ_FIX: begin
        l_we       = 1'b1;
        l_wa       = prev[AW-1:0];
        l_wd       = ent;
        state_next = S_DONE;
      end

      S_CAN_RD: begin
        if (cur == NIL) begin
          state_next = S_DONE;
        end else begin
          state_next = S_CAN_EV;
        end
      end

      S_CAN_EV: begin
        cur_next = l_rd;
        if (p_rd[PAY_W-1:HID_W] == req.msg_key) begin
          // Unlink and return the entry to the free list.
          l_we           = 1'b1;
          l_wa           = cur[AW-1:0];
          l_wd           = free_head;
          free_head_next = cur;
          if (count != '0) begin
            count_next = count - CW'(1);
          end
          if (tail == cur) begin
            tail_next = prev;
          end
          if (prev == NIL) begin
            head_next  = l_rd;
            state_next = S_CAN_RD;
          end else begin
            state_next = S_CAN_FIX;
          end
        end else begin
          prev_next  = cur;
          state_next = S_CAN_RD;
        end
      end

      S_CAN_FIX: begin
        l_we       = 1'b1;
        l_wa       = prev[AW-1:0];
        l_wd       = cur;
        state_next = S_CAN_RD;
      end

      S_DISP: begin
        // A message still in flight is recycled first.
        if (inflight != NIL) begin
          l_we           = 1'b1;
          l_wa           = inflight[AW-1:0];
          l_wd           = free_head;
          free_head_next = inflight;
          inflight_next  = NIL;
        end
        if (head == NIL) begin
          cur_time_next   = req.event_time;
          res_next.status = ST_NOT_DUE;
          state_next      = S_DONE;
        end else begin
          rd_addr    = head[AW-1:0];
          state_next = S_DISP_EV;
        end
      end

      S_DISP_EV: begin
        if (t_rd <= req.event_time) begin
          if (t_rd > cur_time) begin
            cur_time_next = t_rd;
          end
          head_next = l_rd;
          if (l_rd == NIL) begin
            tail_next = NIL;
          end
          if (count != '0) begin
            count_next = count - CW'(1);
          end
          l_we                 = 1'b1;
          l_wa                 = head[AW-1:0];
          l_wd                 = NIL;
          inflight_next        = head;
          res_next.msg_valid   = 1'b1;
          res_next.msg_time    = t_rd;
          res_next.out_key     = p_rd[PAY_W-1:HID_W];
          res_next.out_handler = p_rd[HID_W-1:0];
        end else begin
          cur_time_next   = req.event_time;
          res_next.status = ST_NOT_DUE;
        end
        state_next = S_DONE;
      end

      S_CPL: begin
        if (inflight == NIL) begin
          res_next.status = ST_NO_INFLIGHT;
          state_next      = S_DONE;
        end else begin
          inflight_next = NIL;
          if (req.handled) begin
            l_we           = 1'b1;
            l_wa           = inflight[AW-1:0];
            l_wd           = free_head;
            free_head_next = inflight;
            state_next     = S_DONE;
          end else begin
            t_we          = 1'b1;
            t_wa          = inflight[AW-1:0];
            t_wd          = retry_time;
            ent_next      = inflight;
            ins_time_next = retry_time;
            prev_next     = NIL;
            cur_next      = head;
            state_next    = S_ENQ_RD;
          end
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_q_next            = res;
          out_q_next.used_count = CNT_OUT_W'(count);
          out_valid_next        = 1'b1;
          state_next            = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Configuration writes; writing the start time presets the clock.
    if (cfg_we) begin
      if (cfg_index == REG_RETRY) begin
        retry_next = cfg_data;
      end
      if (cfg_index == REG_START) begin
        cur_time_next = cfg_data;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(POOL_DEPTH))
    else $error("queued count exceeds pool depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted word did not start processing");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((head == NIL) == (tail == NIL)))
    else $error("queue head and tail disagree on empty");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((head == NIL) == (count == '0)))
    else $error("queue count disagrees with empty queue");

endmodule
